>>> hdl/dmpwf_pkg.sv
// Shared widths, constants, register indexes and helpers for the wall-follow PID core.
`default_nettype none

package dmpwf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 10;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Internal arithmetic widths
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int ERR_W      = DIFF_W + 1;
    localparam int DERR_W     = ERR_W + 1;
    localparam int INTEG_W    = 32;
    localparam int MUL_A_W    = INTEG_W;
    localparam int MUL_B_W    = DT_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 44;
    localparam int GAIN_SHIFT = 10;
    localparam int ADJ_W      = ACC_W - GAIN_SHIFT;
    localparam int DUTY_SUM_W = ADJ_W + 1;

    // Divider: |kd * derr| stays below 2^22
    localparam int DIV_NUM_W  = 22;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    // Base duties and reset values
    localparam logic [DUTY_W-1:0] RIGHT_BASE_DUTY = 8'd128;
    localparam logic [DUTY_W-1:0] LEFT_BASE_DUTY  = 8'd128;
    localparam logic [GAIN_W-1:0] THRESH_RESET    = 10'd512;

    // Rounding bias so that the gain shift truncates toward zero
    localparam logic [ACC_W-1:0] GAIN_BIAS = ACC_W'((1 << GAIN_SHIFT) - 1);

    // Integral saturation limits
    localparam logic signed [INTEG_W+1:0] INTEG_MAX = (INTEG_W+2)'(34'sh0_7FFF_FFFF);
    localparam logic signed [INTEG_W+1:0] INTEG_MIN = (INTEG_W+2)'(34'sh3_8000_0000);

    localparam logic signed [DUTY_SUM_W-1:0] DUTY_CEIL = DUTY_SUM_W'(255);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RIGHT_PROP  = 3'd0,
        REG_RIGHT_INTEG = 3'd1,
        REG_RIGHT_DERIV = 3'd2,
        REG_LEFT_PROP   = 3'd3,
        REG_LEFT_INTEG  = 3'd4,
        REG_LEFT_DERIV  = 3'd5,
        REG_HEAD_THRESH = 3'd6
    } cfg_reg_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Saturate a signed duty sum to 0..255
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DUTY_SUM_W-1:0] v);
        logic [DUTY_W-1:0] res;
        if (v[DUTY_SUM_W-1]) begin
            res = '0;
        end
        else if (v > DUTY_CEIL) begin
            res = '1;
        end
        else begin
            res = v[DUTY_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/dual_motor_pid_wall_follow_core.sv
// Top level of the two-motor PID wall-follow controller with front obstacle reverse.
//
// Usage:
//   Input channel (in_valid / in_stall): one request carries left, right and front
//   IR samples plus elapsed_ms. in_stall is high while a request is being worked on.
//   Output channel (out_valid / out_stall): one result per request with both duties,
//   the left reverse duty and the lamp. The result sits in an output register, so a
//   stalled receiver only holds the block once the next result is ready to load.
//   Configuration: cfg_we / cfg_index / cfg_data write the six gains and the front
//   threshold; write only while no request is in flight. Indexes above six are ignored.
// Sequencing:
//   The derivative term runs the 22-step divider once per motor, skipped when
//   elapsed_ms is zero; all products share a single 32x17 multiplier. A new request
//   is taken the cycle after the result is loaded into the output register.
// Reset:
//   Clears the reference, previous error, integral and output valid; gains reset to
//   zero and the threshold to 512. The first request after reset latches the reference.
`default_nettype none

module dual_motor_pid_wall_follow_core
    import dmpwf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   left_sample,
    input  logic [SAMPLE_W-1:0]   right_sample,
    input  logic [SAMPLE_W-1:0]   front_sample,
    input  logic [DT_W-1:0]       elapsed_ms,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     right_duty,
    output logic [DUTY_W-1:0]     left_duty,
    output logic [DUTY_W-1:0]     left_reverse_duty,
    output logic                  lamp_on,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ERR    = 11'b000_0000_0010,
        S_IMUL   = 11'b000_0000_0100,
        S_IADD   = 11'b000_0000_1000,
        S_PMUL   = 11'b000_0001_0000,
        S_KIMUL  = 11'b000_0010_0000,
        S_DMUL   = 11'b000_0100_0000,
        S_DSTART = 11'b000_1000_0000,
        S_DWAIT  = 11'b001_0000_0000,
        S_ADJ    = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [GAIN_W-1:0] r_kp_reg, r_ki_reg, r_kd_reg;
    logic [GAIN_W-1:0] l_kp_reg, l_ki_reg, l_kd_reg;
    logic [GAIN_W-1:0] thresh_reg;

    // Controller state
    logic signed [DIFF_W-1:0]  ref_reg;
    logic                      ref_valid_reg;
    logic signed [ERR_W-1:0]   prev_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;

    // Request payload and working registers
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [SAMPLE_W-1:0]       front_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [DERR_W-1:0]  derr_reg;
    logic signed [DERR_W-1:0]  derr_next;
    logic                      side_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      dneg_reg;
    logic [DUTY_W-1:0]         rduty_calc_reg;
    logic [DUTY_W-1:0]         lduty_calc_reg;

    // Output register
    logic                      out_valid_reg;
    logic [DUTY_W-1:0]         right_duty_reg;
    logic [DUTY_W-1:0]         left_duty_reg;
    logic [DUTY_W-1:0]         left_rev_reg;
    logic                      lamp_reg;

    logic                      in_take;
    logic                      out_load;
    logic signed [DIFF_W-1:0]  in_diff;
    logic [GAIN_W-1:0]         kp_sel, ki_sel, kd_sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [INTEG_W+1:0] integ_sum;
    logic [PROD_W-1:0]         prod_mag;
    logic [DIV_NUM_W-1:0]      div_num;
    logic                      div_start;
    div_stat_t                 div_stat;
    logic [DIV_NUM_W-1:0]      div_quot;
    logic signed [ACC_W-1:0]   quot_ext;
    logic signed [ACC_W-1:0]   dterm;
    logic [ACC_W-1:0]          acc_bias;
    logic signed [ADJ_W-1:0]   adj;
    logic signed [DUTY_SUM_W-1:0] duty_sum;
    logic [DUTY_W-1:0]         duty_sat;
    logic                      reversing;

    assign in_take  = (state_reg == S_IDLE) && in_valid;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign in_diff  = DIFF_W'(left_sample) - DIFF_W'(right_sample);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_kp_reg   <= '0;
            r_ki_reg   <= '0;
            r_kd_reg   <= '0;
            l_kp_reg   <= '0;
            l_ki_reg   <= '0;
            l_kd_reg   <= '0;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RIGHT_PROP:  r_kp_reg   <= cfg_data;
                REG_RIGHT_INTEG: r_ki_reg   <= cfg_data;
                REG_RIGHT_DERIV: r_kd_reg   <= cfg_data;
                REG_LEFT_PROP:   l_kp_reg   <= cfg_data;
                REG_LEFT_INTEG:  l_ki_reg   <= cfg_data;
                REG_LEFT_DERIV:  l_kd_reg   <= cfg_data;
                REG_HEAD_THRESH: thresh_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_ERR;
            S_ERR:    state_next = S_IMUL;
            S_IMUL:   state_next = S_IADD;
            S_IADD:   state_next = S_PMUL;
            S_PMUL:   state_next = S_KIMUL;
            S_KIMUL:  state_next = S_DMUL;
            S_DMUL:   state_next = S_DSTART;
            S_DSTART: state_next = (dt_reg != '0) ? S_DWAIT : S_ADJ;
            S_DWAIT:  if (div_stat.done) state_next = S_ADJ;
            S_ADJ:    state_next = side_reg ? S_OUT : S_PMUL;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Error and its change since the last request
    assign err_next  = ERR_W'(ref_reg) - ERR_W'(diff_reg);
    assign derr_next = DERR_W'(err_next) - DERR_W'(prev_reg);

    // Integral update with saturation to the signed 32-bit range
    assign integ_sum = (INTEG_W+2)'(integ_reg) + (INTEG_W+2)'(prod_reg);
    always_comb
    begin
        if (integ_sum > INTEG_MAX)
        begin
            integ_next = INTEG_MAX[INTEG_W-1:0];
        end
        else if (integ_sum < INTEG_MIN)
        begin
            integ_next = INTEG_MIN[INTEG_W-1:0];
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    // Controller state: reference, previous error, integral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= '0;
            ref_valid_reg <= 1'b0;
            prev_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            if (in_take && !ref_valid_reg)
            begin
                ref_reg       <= in_diff;
                ref_valid_reg <= 1'b1;
            end
            if (state_reg == S_ERR)
            begin
                prev_reg <= err_next;
            end
            if (state_reg == S_IADD)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // Gain selection for the motor being worked on
    assign kp_sel = side_reg ? l_kp_reg : r_kp_reg;
    assign ki_sel = side_reg ? l_ki_reg : r_ki_reg;
    assign kd_sel = side_reg ? l_kd_reg : r_kd_reg;

    // Shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_IMUL:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = {1'b0, dt_reg};
            end
            S_PMUL:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(kp_sel);
            end
            S_KIMUL:
            begin
                mul_a = integ_reg;
                mul_b = MUL_B_W'(ki_sel);
            end
            S_DMUL:
            begin
                mul_a = MUL_A_W'(derr_reg);
                mul_b = MUL_B_W'(kd_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Derivative divide: magnitude in, sign applied to the quotient
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_num   = prod_mag[DIV_NUM_W-1:0];
    assign div_start = (state_reg == S_DSTART) && (dt_reg != '0);

    dmpwf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dt_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign quot_ext = ACC_W'(div_quot);
    assign dterm    = dneg_reg ? -quot_ext : quot_ext;

    // Accumulate the P, I and D terms
    always_comb
    begin
        acc_next = acc_reg;
        unique case (state_reg)
            S_KIMUL: acc_next = ACC_W'(prod_reg);
            S_DMUL:  acc_next = acc_reg + ACC_W'(prod_reg);
            S_DWAIT: if (div_stat.done) acc_next = acc_reg + dterm;
            default: acc_next = acc_reg;
        endcase
    end

    // Scale by 1/1024 toward zero, add to or subtract from base, saturate
    assign acc_bias  = acc_reg + (acc_reg[ACC_W-1] ? GAIN_BIAS : '0);
    assign adj       = acc_bias[ACC_W-1:GAIN_SHIFT];
    assign duty_sum  = side_reg ? (DUTY_SUM_W'(LEFT_BASE_DUTY) - DUTY_SUM_W'(adj))
                                : (DUTY_SUM_W'(RIGHT_BASE_DUTY) + DUTY_SUM_W'(adj));
    assign duty_sat  = clamp_duty(duty_sum);
    assign reversing = (front_reg > thresh_reg);

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (in_take)
        begin
            diff_reg  <= in_diff;
            front_reg <= front_sample;
            dt_reg    <= elapsed_ms;
        end
        if (state_reg == S_ERR)
        begin
            err_reg  <= err_next;
            derr_reg <= derr_next;
        end
        if (state_reg == S_DSTART)
        begin
            dneg_reg <= prod_reg[PROD_W-1];
        end
        if (state_reg == S_ADJ)
        begin
            if (side_reg)
            begin
                lduty_calc_reg <= duty_sat;
            end
            else
            begin
                rduty_calc_reg <= duty_sat;
            end
        end
    end

    // Motor select: right first, then left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 1'b0;
        end
        else if (in_take)
        begin
            side_reg <= 1'b0;
        end
        else if (state_reg == S_ADJ)
        begin
            side_reg <= 1'b1;
        end
    end

    // Output register: load a new result, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            right_duty_reg <= rduty_calc_reg;
            left_duty_reg  <= reversing ? '0 : lduty_calc_reg;
            left_rev_reg   <= reversing ? LEFT_BASE_DUTY : '0;
            lamp_reg       <= reversing;
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign right_duty        = right_duty_reg;
    assign left_duty         = left_duty_reg;
    assign left_reverse_duty = left_rev_reg;
    assign lamp_on           = lamp_reg;

`ifndef SYNTHESIS
    // Divider runs only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DWAIT))
        else $error("divider busy outside the derivative wait");

    // Reference, once latched, stays latched
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ref_valid_reg))
        else $error("reference valid dropped");

    // A new result only appears out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output valid rose outside the result load");

    // Lamp and forward left duty are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && lamp_reg) |-> (left_duty_reg == '0))
        else $error("left forward duty nonzero while reversing");

    // Both motors are worked before a result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> side_reg)
        else $error("result load before left motor finished");
`endif

endmodule

`default_nettype wire

>>> hdl/dmpwf_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none

module dmpwf_div
    import dmpwf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DT_W-1:0]      den,
    output div_stat_t            stat,
    output logic [DIV_NUM_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DT_W-1:0]      rem_reg;
    logic [DT_W-1:0]      den_reg;

    logic [DT_W:0]        trial;
    logic [DT_W:0]        trial_sub;
    logic                 fits;
    logic                 last_step;

    // Shift in the next dividend bit and try the subtract
    assign trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});
    assign last_step = (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1));

    // Control: run for DIV_NUM_W steps, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits replace dividend bits from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = num_reg;

endmodule

`default_nettype wire
